### hw/rtl/inverse_perspective_ground_map_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inverse perspective ground mapper.
// Concurrent checks sampled on clk; IPGM_ASSERT is held off while rst_n is low, IPGM_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef INVERSE_PERSPECTIVE_GROUND_MAP_TOP_ASSERT_SVH
`define INVERSE_PERSPECTIVE_GROUND_MAP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define IPGM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipgm assertion failed");
`define IPGM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ipgm assertion failed");
`else
`define IPGM_ASSERT(lbl, prop)
`define IPGM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/ipgm_pkg.sv
// ----------------------------------------------------------------------------
// ipgm_pkg
// Shared constants, codes and types of the ground mapper.
// ----------------------------------------------------------------------------
package ipgm_pkg;

    localparam int OUT_BITS  = 24;
    localparam int QUO_BITS  = 25;
    localparam int SAT_BITS  = QUO_BITS + 3;
    localparam int HGT_BITS  = 16;
    localparam int GRAY_BITS = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 63;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAY_LOW      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAY_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_ROW_X     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_ROW_Y     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_ROW_Z     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DENOM_ROW     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAMERA_HEIGHT = 3'd6;

    localparam logic [GRAY_BITS-1:0] GRAY_LOW_RESET  = 8'd245;
    localparam logic [GRAY_BITS-1:0] GRAY_HIGH_RESET = 8'd255;

    localparam logic [21:0] GRAY_WR  = 22'd4899;
    localparam logic [21:0] GRAY_WG  = 22'd9617;
    localparam logic [21:0] GRAY_WB  = 22'd1868;
    localparam logic [21:0] GRAY_RND = 22'd8192;

    localparam logic [1:0] KIND_GROUND    = 2'd0;
    localparam logic [1:0] KIND_ZERO_DEN  = 2'd1;
    localparam logic [1:0] KIND_FRAME_END = 2'd2;

    localparam logic signed [SAT_BITS-1:0] OUT_MAX = SAT_BITS'(8388607);
    localparam logic signed [SAT_BITS-1:0] OUT_MIN = -SAT_BITS'(8388608);

    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic                frame_end;
        logic [HGT_BITS-1:0] height;
    } tag_t;

    function automatic logic [OUT_BITS-1:0] sat_point(
        input logic signed [SAT_BITS-1:0] v,
        input logic                       ovf,
        input logic                       neg
    );
        logic signed [SAT_BITS-1:0] c;
        if (ovf)
        begin
            c = neg ? OUT_MIN : OUT_MAX;
        end
        else if (v > OUT_MAX)
        begin
            c = OUT_MAX;
        end
        else if (v < OUT_MIN)
        begin
            c = OUT_MIN;
        end
        else
        begin
            c = v;
        end
        return c[OUT_BITS-1:0];
    endfunction

endpackage

### hw/rtl/ipgm_intf.sv
// ----------------------------------------------------------------------------
// ipgm interfaces
// Pixel, ground point and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface ipgm_pix_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  last_pixel;
    modport source (output valid, red, green, blue, col, row, last_pixel, input ready);
    modport sink (input valid, red, green, blue, col, row, last_pixel, output ready);
endinterface

interface ipgm_pt_if;
    logic        valid;
    logic        ready;
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic [23:0] point_z;
    logic [1:0]  kind;
    logic        frame_end;
    modport source (output valid, point_x, point_y, point_z, kind, frame_end, input ready);
    modport sink (input valid, point_x, point_y, point_z, kind, frame_end, output ready);
endinterface

interface ipgm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [62:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ipgm_front.sv
// ----------------------------------------------------------------------------
// ipgm_front
// Gray band test, coefficient dot products, height scaling and magnitudes.
// ----------------------------------------------------------------------------
module ipgm_front
    import ipgm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COEF_BITS  = 21,
    parameter int NUM_BITS   = COEF_BITS + COORD_BITS + 20,
    parameter int DEN_BITS   = COEF_BITS + COORD_BITS + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    input  logic                  last_pixel,
    input  logic [GRAY_BITS-1:0]  gray_low,
    input  logic [GRAY_BITS-1:0]  gray_high,
    input  logic [CFG_DATA_BITS-1:0] coef_rows [4],
    input  logic [HGT_BITS-1:0]   height,
    output tag_t                  tag,
    output logic [NUM_BITS-1:0]   num_mag [3],
    output logic                  num_neg [3],
    output logic [DEN_BITS-1:0]   den_mag,
    output logic                  den_neg
);

    localparam int PW = COEF_BITS + COORD_BITS + 1;
    localparam int UB = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam logic [COORD_BITS-1:0] COORD_MASK = COORD_BITS'((32'd1 << UB) - 32'd1);

    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    assign u = col & COORD_MASK;
    assign v = row & COORD_MASK;

    tag_t                        tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [21:0]                 gsum_reg;
    logic signed [PW-1:0]        pu_reg [4];
    logic signed [PW-1:0]        pv_reg [4];
    logic signed [COEF_BITS-1:0] pc_reg [4];
    logic signed [DEN_BITS-1:0]  dot_reg [4];
    logic signed [NUM_BITS-1:0]  prod_reg [3];
    logic signed [DEN_BITS-1:0]  den_reg;
    logic [NUM_BITS-1:0]         mag_reg [3];
    logic                        neg_reg [3];
    logic [DEN_BITS-1:0]         dmag_reg;
    logic                        dneg_reg;

    logic [GRAY_BITS-1:0] gray;
    logic                 keep_next;
    assign gray      = gsum_reg[21:14];
    assign keep_next = (gray >= gray_low) && (gray <= gray_high);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= '{valid: in_valid, kind: KIND_GROUND, frame_end: last_pixel,
                          height: height};
            tag2_reg <= '{valid: tag1_reg.valid && (keep_next || tag1_reg.frame_end),
                          kind: keep_next ? KIND_GROUND : KIND_FRAME_END,
                          frame_end: tag1_reg.frame_end, height: tag1_reg.height};
            tag3_reg <= tag2_reg;
            tag4_reg <= '{valid: tag3_reg.valid,
                          kind: (tag3_reg.kind == KIND_GROUND && den_reg == '0)
                                ? KIND_ZERO_DEN : tag3_reg.kind,
                          frame_end: tag3_reg.frame_end, height: tag3_reg.height};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gsum_reg <= {14'd0, red} * GRAY_WR + {14'd0, green} * GRAY_WG
                      + {14'd0, blue} * GRAY_WB + GRAY_RND;
            for (int i = 0; i < 4; i++)
            begin
                pu_reg[i] <= $signed(coef_rows[i][COEF_BITS-1:0]) * $signed({1'b0, u});
                pv_reg[i] <= $signed(coef_rows[i][2*COEF_BITS-1:COEF_BITS])
                           * $signed({1'b0, v});
                pc_reg[i] <= $signed(coef_rows[i][3*COEF_BITS-1:2*COEF_BITS]);
                dot_reg[i] <= DEN_BITS'(pu_reg[i]) + DEN_BITS'(pv_reg[i])
                            + DEN_BITS'(pc_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= dot_reg[i] * $signed({1'b0, tag2_reg.height});
                mag_reg[i]  <= prod_reg[i][NUM_BITS-1] ? (~prod_reg[i] + 1'b1)
                                                        : prod_reg[i];
                neg_reg[i]  <= prod_reg[i][NUM_BITS-1];
            end
            den_reg  <= dot_reg[3];
            dmag_reg <= den_reg[DEN_BITS-1] ? (~den_reg + 1'b1) : den_reg;
            dneg_reg <= den_reg[DEN_BITS-1];
        end
    end

    assign tag     = tag4_reg;
    assign num_mag = mag_reg;
    assign num_neg = neg_reg;
    assign den_mag = dmag_reg;
    assign den_neg = dneg_reg;

endmodule

### hw/rtl/ipgm_div.sv
// ----------------------------------------------------------------------------
// ipgm_div
// Pipelined restoring divider, one quotient bit per stage, three numerators
// over a shared denominator, with an overflow flag for large quotients.
// ----------------------------------------------------------------------------
module ipgm_div
    import ipgm_pkg::*;
#(
    parameter int NUM_BITS = 53,
    parameter int DEN_BITS = 36
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  tag_t                tag_in,
    input  logic [NUM_BITS-1:0] num_mag [3],
    input  logic                num_neg [3],
    input  logic [DEN_BITS-1:0] den_mag,
    input  logic                den_neg,
    output tag_t                tag,
    output logic [QUO_BITS-1:0] quo [3],
    output logic                ovf [3],
    output logic                neg [3]
);

    localparam int W = DEN_BITS + QUO_BITS;

    tag_t                tag_reg [QUO_BITS+1];
    logic [W-1:0]        rem_reg [QUO_BITS][3];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS+1][3];
    logic                ovf_reg [QUO_BITS+1][3];
    logic                neg_reg [QUO_BITS+1][3];
    logic [DEN_BITS-1:0] den_reg [QUO_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den_mag;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= W'(num_mag[i]);
                quo_reg[0][i] <= '0;
                ovf_reg[0][i] <= W'(num_mag[i]) >= {den_mag, {QUO_BITS{1'b0}}};
                neg_reg[0][i] <= num_neg[i] ^ den_neg;
            end
        end
    end

    for (genvar j = 1; j <= QUO_BITS; j++)
    begin : g_stage
        localparam int K = QUO_BITS - j;
        logic [W-1:0] dsh;
        logic         take [3];
        assign dsh = W'(den_reg[j-1]) << K;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                take[i] = rem_reg[j-1][i] >= dsh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else if (en)
            begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    quo_reg[j][i] <= quo_reg[j-1][i] | (QUO_BITS'(take[i]) << K);
                    ovf_reg[j][i] <= ovf_reg[j-1][i];
                    neg_reg[j][i] <= neg_reg[j-1][i];
                end
            end
        end

        if (j < QUO_BITS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[j] <= den_reg[j-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_reg[j][i] <= take[i] ? (rem_reg[j-1][i] - dsh)
                                                 : rem_reg[j-1][i];
                    end
                end
            end
        end
    end

    assign tag = tag_reg[QUO_BITS];
    assign quo = quo_reg[QUO_BITS];
    assign ovf = ovf_reg[QUO_BITS];
    assign neg = neg_reg[QUO_BITS];

endmodule

### hw/rtl/inverse_perspective_ground_map_top.sv
// ----------------------------------------------------------------------------
// inverse_perspective_ground_map_top
// Projects band-passed gray pixels onto the road plane in fixed point.
//
//   channel  role    moves
//   pix      sink    one pixel item: color, column, row, last_pixel
//   pts      source  one ground point item: x, y, z, kind, frame_end
//   cfg      sink    one register write: index, data
//
// One item enters per cycle while the output register is not stalled; the
// restoring divider resolves one quotient bit per stage.
// Reset clears the valid bits and loads the register reset values.
// A stalled output register freezes the whole pipeline, so no item is lost.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "inverse_perspective_ground_map_top_assert.svh"

module inverse_perspective_ground_map_top
    import ipgm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COEF_BITS  = 21
)
(
    input logic        clk,
    input logic        rst_n,
    ipgm_pix_if.sink   pix,
    ipgm_pt_if.source  pts,
    ipgm_cfg_if.sink   cfg
);

    localparam int DEN_BITS = COEF_BITS + COORD_BITS + 3;
    localparam int NUM_BITS = DEN_BITS + HGT_BITS + 1;

    logic [GRAY_BITS-1:0]     gray_low_reg, gray_high_reg;
    logic [CFG_DATA_BITS-1:0] rows_reg [4];
    logic [HGT_BITS-1:0]      height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_low_reg  <= GRAY_LOW_RESET;
            gray_high_reg <= GRAY_HIGH_RESET;
            rows_reg      <= '{default: '0};
            height_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GRAY_LOW:      gray_low_reg  <= cfg.data[GRAY_BITS-1:0];
                CFG_GRAY_HIGH:     gray_high_reg <= cfg.data[GRAY_BITS-1:0];
                CFG_MAP_ROW_X:     rows_reg[0]   <= cfg.data;
                CFG_MAP_ROW_Y:     rows_reg[1]   <= cfg.data;
                CFG_MAP_ROW_Z:     rows_reg[2]   <= cfg.data;
                CFG_DENOM_ROW:     rows_reg[3]   <= cfg.data;
                CFG_CAMERA_HEIGHT: height_reg    <= cfg.data[HGT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en        = !out_valid_reg || pts.ready;
    assign pix.ready = en;

    tag_t                ftag, dtag;
    logic [NUM_BITS-1:0] num_mag [3];
    logic                num_neg [3];
    logic [DEN_BITS-1:0] den_mag;
    logic                den_neg;
    logic [QUO_BITS-1:0] quo [3];
    logic                ovf [3];
    logic                qneg [3];

    ipgm_front #(
        .COORD_BITS (COORD_BITS),
        .COEF_BITS  (COEF_BITS),
        .NUM_BITS   (NUM_BITS),
        .DEN_BITS   (DEN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (pix.valid),
        .red        (pix.red),
        .green      (pix.green),
        .blue       (pix.blue),
        .col        (pix.col),
        .row        (pix.row),
        .last_pixel (pix.last_pixel),
        .gray_low   (gray_low_reg),
        .gray_high  (gray_high_reg),
        .coef_rows  (rows_reg),
        .height     (height_reg),
        .tag        (ftag),
        .num_mag    (num_mag),
        .num_neg    (num_neg),
        .den_mag    (den_mag),
        .den_neg    (den_neg)
    );

    ipgm_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (ftag),
        .num_mag (num_mag),
        .num_neg (num_neg),
        .den_mag (den_mag),
        .den_neg (den_neg),
        .tag     (dtag),
        .quo     (quo),
        .ovf     (ovf),
        .neg     (qneg)
    );

    logic signed [SAT_BITS-1:0] qs [3];
    logic [OUT_BITS-1:0]        pt_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = qneg[i] ? -$signed({3'b000, quo[i]}) : $signed({3'b000, quo[i]});
        end
        pt_next[0] = sat_point(qs[0], ovf[0], qneg[0]);
        pt_next[1] = sat_point(qs[1], ovf[1], qneg[1]);
        pt_next[2] = sat_point(qs[2] - SAT_BITS'({1'b0, dtag.height}), ovf[2], qneg[2]);
        if (dtag.kind != KIND_GROUND)
        begin
            pt_next = '{default: '0};
        end
    end

    logic [OUT_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [1:0]          kind_reg;
    logic                fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dtag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= pt_next[0];
            py_reg   <= pt_next[1];
            pz_reg   <= pt_next[2];
            kind_reg <= dtag.kind;
            fe_reg   <= dtag.frame_end;
        end
    end

    assign pts.valid     = out_valid_reg;
    assign pts.point_x   = px_reg;
    assign pts.point_y   = py_reg;
    assign pts.point_z   = pz_reg;
    assign pts.kind      = kind_reg;
    assign pts.frame_end = fe_reg;

    `IPGM_ASSERT(a_kind_code, pts.valid |-> (pts.kind == KIND_GROUND || pts.kind == KIND_ZERO_DEN || pts.kind == KIND_FRAME_END))
    `IPGM_ASSERT(a_no_point_zero, (pts.valid && pts.kind != KIND_GROUND) |-> (pts.point_x == '0 && pts.point_y == '0 && pts.point_z == '0))
    `IPGM_ASSERT(a_frame_end_kind, (pts.valid && pts.kind == KIND_FRAME_END) |-> pts.frame_end)
    `IPGM_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid_reg)

endmodule
